FILE: rtl/core/clip_timeline_position_resolver_defines.svh
// Assertion macros for the clip timeline position resolver checker.
// Used by ctpr_checker; depends on nothing else.
`ifndef CLIP_TIMELINE_POSITION_RESOLVER_DEFINES_SVH
`define CLIP_TIMELINE_POSITION_RESOLVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CTPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CTPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ctpr_pkg.sv
// Shared types and constants for the clip timeline position resolver.
// No dependencies.
`timescale 1ns / 1ps

package ctpr_pkg;

    localparam int MAX_CLIPS = 16;
    localparam int TIME_BITS = 40;
    localparam int LINE_BITS = TIME_BITS + 4;
    localparam int POS_BITS  = LINE_BITS + 1;
    localparam int IDX_BITS  = $clog2(MAX_CLIPS);
    localparam int CNT_BITS  = $clog2(MAX_CLIPS + 1);

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_TRIM = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APP_SUB,
        S_APP_ADD,
        S_RD,
        S_GE,
        S_LT,
        S_ADD,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

FILE: rtl/core/clip_timeline_position_resolver.sv
// Clip timeline position resolver: clip table, cursor and sequenced scan.
// Depends on ctpr_pkg.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears on the o_ result ports
// for exactly one cycle with o_valid high, and the receiver cannot stall it.
// All length, end, compare and source-offset arithmetic runs through one
// shared 45-bit adder/subtractor stepped by a small sequencer: clear and
// unused codes go from decode straight to done; an append subtracts trim-in
// from trim-out and then adds the length to the cursor (it skips both when the
// table is full, and the add when trim-out lies before trim-in); a resolve
// scans entries with a read, a start compare and, if that passes, an end
// compare, then does the source add on a hit. o_total_duration and
// o_clip_count track the table at all times and are valid with o_valid.
// There is no clearing pass after reset: only entries below the count are
// ever read.
module clip_timeline_position_resolver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_command,
    input  logic [ctpr_pkg::TIME_BITS-1:0]     i_trim_in,
    input  logic [ctpr_pkg::TIME_BITS-1:0]     i_trim_out,
    input  logic signed [ctpr_pkg::POS_BITS-1:0] i_position,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic                               o_found,
    output logic [ctpr_pkg::IDX_BITS-1:0]      o_clip_index,
    output logic [ctpr_pkg::TIME_BITS-1:0]     o_source_pos,
    output logic [ctpr_pkg::LINE_BITS-1:0]     o_total_duration,
    output logic [ctpr_pkg::CNT_BITS-1:0]      o_clip_count
);
    import ctpr_pkg::*;

    t_state r_state, n_state;

    logic [1:0]           r_cmd;
    logic [TIME_BITS-1:0] r_tin, r_tout;
    logic [POS_BITS-1:0]  r_pos;
    logic [TIME_BITS-1:0] r_len, n_len;
    logic [LINE_BITS-1:0] r_off, n_off;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [LINE_BITS-1:0] r_cursor, n_cursor;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    logic [1:0]           r_status, n_status;
    logic                 r_found, n_found;
    logic [IDX_BITS-1:0]  r_index, n_index;
    logic [TIME_BITS-1:0] r_spos, n_spos;

    logic [TIME_BITS-1:0] r_src_mem   [MAX_CLIPS];
    logic [LINE_BITS-1:0] r_start_mem [MAX_CLIPS];
    logic [LINE_BITS-1:0] r_end_mem   [MAX_CLIPS];
    logic [TIME_BITS-1:0] r_rd_src;
    logic [LINE_BITS-1:0] r_rd_start, r_rd_end;

    t_alu_op             alu_op;
    logic [POS_BITS-1:0] alu_a, alu_b, alu_b_eff, alu_sum;
    logic                alu_carry;
    logic [LINE_BITS-1:0] w_end;
    logic                w_accept, w_last;

    assign w_accept = start && !busy;
    assign w_last   = ({1'b0, r_idx} + CNT_BITS'(1)) >= r_count;

    // Shared adder: subtract is a + ~b + 1, carry out means a >= b.
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (r_state)
            S_APP_SUB: begin
                alu_op = ALU_SUB;
                alu_a  = POS_BITS'(r_tout);
                alu_b  = POS_BITS'(r_tin);
            end
            S_APP_ADD: begin
                alu_a = POS_BITS'(r_cursor);
                alu_b = POS_BITS'(r_len);
            end
            S_GE: begin
                alu_op = ALU_SUB;
                alu_a  = POS_BITS'(r_pos[LINE_BITS-1:0]);
                alu_b  = POS_BITS'(r_rd_start);
            end
            S_LT: begin
                alu_op = ALU_SUB;
                alu_a  = POS_BITS'(r_pos[LINE_BITS-1:0]);
                alu_b  = POS_BITS'(r_rd_end);
            end
            S_ADD: begin
                alu_a = POS_BITS'(r_rd_src);
                alu_b = POS_BITS'(r_off);
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    assign alu_b_eff = (alu_op == ALU_SUB) ? ~alu_b : alu_b;
    assign {alu_carry, alu_sum} = {1'b0, alu_a} + {1'b0, alu_b_eff}
                                + (POS_BITS + 1)'(alu_op == ALU_SUB);
    assign w_end = alu_sum[LINE_BITS] ? {LINE_BITS{1'b1}} : alu_sum[LINE_BITS-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_cmd)
                    CMD_APPEND: begin
                        n_state = (r_count >= CNT_BITS'(MAX_CLIPS)) ? S_DONE : S_APP_SUB;
                    end
                    CMD_RESOLVE: begin
                        n_state = (r_pos[POS_BITS-1] || r_count == '0) ? S_DONE : S_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_APP_SUB: begin
                n_state = alu_carry ? S_APP_ADD : S_DONE;
            end
            S_APP_ADD: begin
                n_state = S_DONE;
            end
            S_RD: begin
                n_state = S_GE;
            end
            S_GE: begin
                if (alu_carry)   n_state = S_LT;
                else if (w_last) n_state = S_DONE;
                else             n_state = S_RD;
            end
            S_LT: begin
                if (!alu_carry)  n_state = S_ADD;
                else if (w_last) n_state = S_DONE;
                else             n_state = S_RD;
            end
            S_ADD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy    = (r_state != S_IDLE) || !i_rst_n;
        o_valid = (r_state == S_DONE);
    end

    always_comb begin
        n_len    = r_len;
        n_off    = r_off;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_status = r_status;
        n_found  = r_found;
        n_index  = r_index;
        n_spos   = r_spos;
        case (r_state)
            S_DECODE: begin
                n_status = ST_OK;
                n_found  = 1'b0;
                n_index  = '0;
                n_spos   = '0;
                n_idx    = '0;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_count  = '0;
                        n_cursor = '0;
                    end
                    CMD_APPEND: begin
                        if (r_count >= CNT_BITS'(MAX_CLIPS)) n_status = ST_FULL;
                    end
                    CMD_RESOLVE: begin
                        if (r_pos[POS_BITS-1] || r_count == '0) n_status = ST_MISS;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_APP_SUB: begin
                n_len = alu_sum[TIME_BITS-1:0];
                if (!alu_carry) n_status = ST_TRIM;
            end
            S_APP_ADD: begin
                n_cursor = w_end;
                n_count  = r_count + CNT_BITS'(1);
            end
            S_GE: begin
                n_off = alu_sum[LINE_BITS-1:0];
                if (!alu_carry && w_last) n_status = ST_MISS;
                else if (!alu_carry)      n_idx = r_idx + IDX_BITS'(1);
            end
            S_LT: begin
                if (alu_carry && w_last) n_status = ST_MISS;
                else if (alu_carry)      n_idx = r_idx + IDX_BITS'(1);
            end
            S_ADD: begin
                n_found = 1'b1;
                n_index = r_idx;
                n_spos  = alu_sum[TIME_BITS-1:0];
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_tin  <= i_trim_in;
            r_tout <= i_trim_out;
            r_pos  <= i_position;
        end
        r_len    <= n_len;
        r_off    <= n_off;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_found  <= n_found;
        r_index  <= n_index;
        r_spos   <= n_spos;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_APP_ADD) begin
            r_src_mem[r_count[IDX_BITS-1:0]]   <= r_tin;
            r_start_mem[r_count[IDX_BITS-1:0]] <= r_cursor;
            r_end_mem[r_count[IDX_BITS-1:0]]   <= w_end;
        end
        if (r_state == S_RD) begin
            r_rd_src   <= r_src_mem[r_idx];
            r_rd_start <= r_start_mem[r_idx];
            r_rd_end   <= r_end_mem[r_idx];
        end
    end

    assign o_status         = r_status;
    assign o_found          = r_found;
    assign o_clip_index     = r_index;
    assign o_source_pos     = r_spos;
    assign o_total_duration = r_cursor;
    assign o_clip_count     = r_count;

endmodule

FILE: rtl/core/ctpr_checker.sv
// Port-level checker for the clip timeline position resolver, and its bind.
// Depends on ctpr_pkg and clip_timeline_position_resolver_defines.svh.
`timescale 1ns / 1ps
`include "clip_timeline_position_resolver_defines.svh"

module ctpr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [1:0]                    o_status,
    input logic                          o_found,
    input logic [ctpr_pkg::IDX_BITS-1:0] o_clip_index,
    input logic [ctpr_pkg::TIME_BITS-1:0] o_source_pos
);
    import ctpr_pkg::*;

    `CTPR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid, "accepted item did not raise busy")
    `CTPR_ASSERT_NEXT(a_valid_release, i_clk, i_rst_n, o_valid, !o_valid && !busy, "result not followed by ready")
    `CTPR_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy, "result shown while idle")
    `CTPR_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, o_valid && o_found, o_status == ST_OK, "hit with bad status")
    `CTPR_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found, o_clip_index == '0 && o_source_pos == '0, "miss with nonzero payload")

endmodule

bind clip_timeline_position_resolver ctpr_checker u_ctpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_status     (o_status),
    .o_found      (o_found),
    .o_clip_index (o_clip_index),
    .o_source_pos (o_source_pos)
);

FILE: sim/clip_timeline_position_resolver_test.sv
// Self-checking testbench for clip_timeline_position_resolver: clear, append, resolve
// and unused-code items are checked against a clip-table predictor kept in the bench.
// Depends on ctpr_pkg and the clip_timeline_position_resolver RTL.
`timescale 1ns / 1ps

module clip_timeline_position_resolver_test;
    import ctpr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [1:0]           status;
        logic                 found;
        logic [IDX_BITS-1:0]  clip_index;
        logic [TIME_BITS-1:0] source_pos;
        logic [LINE_BITS-1:0] total_duration;
        logic [CNT_BITS-1:0]  clip_count;
    } t_timeline_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  i_command;
    logic [TIME_BITS-1:0]        i_trim_in;
    logic [TIME_BITS-1:0]        i_trim_out;
    logic signed [POS_BITS-1:0]  i_position;
    logic                        o_valid;
    logic [1:0]                  o_status;
    logic                        o_found;
    logic [IDX_BITS-1:0]         o_clip_index;
    logic [TIME_BITS-1:0]        o_source_pos;
    logic [LINE_BITS-1:0]        o_total_duration;
    logic [CNT_BITS-1:0]         o_clip_count;

    logic [TIME_BITS-1:0] clip_src_start  [MAX_CLIPS];
    logic [LINE_BITS-1:0] clip_line_start [MAX_CLIPS];
    logic [LINE_BITS-1:0] clip_line_end   [MAX_CLIPS];
    int unsigned          clip_total;
    logic [LINE_BITS-1:0] line_cursor;

    t_timeline_result pending_results[$];
    int               error_count;
    int               sender_idle_pct;

    clip_timeline_position_resolver i_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic t_timeline_result apply_timeline_command(
        input logic [1:0]           cmd,
        input logic [TIME_BITS-1:0] tin,
        input logic [TIME_BITS-1:0] tout,
        input logic [POS_BITS-1:0]  pos
    );
        t_timeline_result     r;
        logic [LINE_BITS:0]   sum;
        logic [LINE_BITS:0]   len;
        logic [LINE_BITS-1:0] praw;
        logic [LINE_BITS-1:0] offset;
        bit                   hit;
        r = '0;
        r.status = ST_OK;
        praw = pos[LINE_BITS-1:0];
        hit = 1'b0;
        case (cmd)
            CMD_CLEAR: begin
                clip_total = 0;
                line_cursor = '0;
            end
            CMD_APPEND: begin
                if (clip_total >= MAX_CLIPS) begin
                    r.status = ST_FULL;
                end else if (tout < tin) begin
                    r.status = ST_TRIM;
                end else begin
                    len = {5'b0, tout - tin};
                    sum = {1'b0, line_cursor} + len;
                    if (sum[LINE_BITS]) begin
                        sum = {1'b0, {LINE_BITS{1'b1}}};
                    end
                    clip_src_start[clip_total] = tin;
                    clip_line_start[clip_total] = line_cursor;
                    clip_line_end[clip_total] = sum[LINE_BITS-1:0];
                    clip_total++;
                    line_cursor = sum[LINE_BITS-1:0];
                end
            end
            CMD_RESOLVE: begin
                r.status = ST_MISS;
                if (!pos[POS_BITS-1]) begin
                    for (int i = 0; i < clip_total && !hit; i++) begin
                        if (praw >= clip_line_start[i] && praw < clip_line_end[i]) begin
                            hit = 1'b1;
                            offset = praw - clip_line_start[i];
                            r.status = ST_OK;
                            r.found = 1'b1;
                            r.clip_index = i[IDX_BITS-1:0];
                            r.source_pos = clip_src_start[i] + offset[TIME_BITS-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        r.total_duration = line_cursor;
        r.clip_count = clip_total[CNT_BITS-1:0];
        return r;
    endfunction

    function automatic logic [63:0] rand_bits64();
        return {$urandom, $urandom};
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_timeline_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item pending: status %0d count %0d",
                         $time, o_status, o_clip_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("found", 64'(want.found), 64'(o_found));
                check_field("clip_index", 64'(want.clip_index), 64'(o_clip_index));
                check_field("source_pos", 64'(want.source_pos), 64'(o_source_pos));
                check_field("total_duration", 64'(want.total_duration),
                            64'(o_total_duration));
                check_field("clip_count", 64'(want.clip_count), 64'(o_clip_count));
            end
        end
    end

    task automatic send_item(
        input logic [1:0]           cmd,
        input logic [TIME_BITS-1:0] tin,
        input logic [TIME_BITS-1:0] tout,
        input logic [POS_BITS-1:0]  pos
    );
        t_timeline_result expected_item;
        start <= 1'b1;
        i_command <= cmd;
        i_trim_in <= tin;
        i_trim_out <= tout;
        i_position <= pos;
        do @(posedge i_clk); while (busy);
        expected_item = apply_timeline_command(cmd, tin, tout, pos);
        pending_results.insert(pending_results.size(), expected_item);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic random_timeline_item();
        int                   pick;
        int                   sel;
        logic [1:0]           cmd;
        logic [TIME_BITS-1:0] tin;
        logic [TIME_BITS-1:0] tout;
        logic [TIME_BITS-1:0] len;
        logic [POS_BITS-1:0]  pos;
        logic [LINE_BITS-1:0] span;
        logic [LINE_BITS-1:0] value;
        pick = $urandom_range(99);
        tin = TIME_BITS'(rand_bits64());
        tout = TIME_BITS'(rand_bits64());
        pos = POS_BITS'(rand_bits64());
        if ((clip_total == MAX_CLIPS && pick < 30) || pick < 4) begin
            cmd = CMD_CLEAR;
        end else if (pick < 7) begin
            cmd = CMD_UNUSED;
        end else if (pick < 55) begin
            cmd = CMD_APPEND;
            case ($urandom_range(3))
                0: tin = TIME_BITS'(rand_bits64());
                1: tin = TIME_BITS'($urandom_range(1000));
                2: tin = TIME_MAX - TIME_BITS'($urandom_range(1000));
                default: tin = TIME_BITS'(rand_bits64() >> $urandom_range(39));
            endcase
            case ($urandom_range(4))
                0: len = '0;
                1, 2: len = TIME_BITS'($urandom_range(1, 5000));
                3: len = TIME_BITS'(rand_bits64() >> $urandom_range(39));
                default: len = TIME_BITS'(rand_bits64());
            endcase
            if ($urandom_range(99) < 8 && tin != 0) begin
                tout = TIME_BITS'(rand_bits64() % 64'(tin));
            end else begin
                tout = (len > TIME_MAX - tin) ? TIME_MAX : tin + len;
            end
        end else begin
            cmd = CMD_RESOLVE;
            sel = $urandom_range(99);
            if (clip_total > 0 && sel < 65) begin
                pick = $urandom_range(clip_total - 1);
                span = clip_line_end[pick] - clip_line_start[pick];
                case ($urandom_range(3))
                    0: value = clip_line_start[pick];
                    1: value = clip_line_end[pick] - LINE_BITS'(1);
                    2: value = clip_line_end[pick];
                    default: value = clip_line_start[pick] +
                                     ((span == 0) ? '0 :
                                      LINE_BITS'(rand_bits64() % 64'(span)));
                endcase
                pos = {1'b0, value};
            end else if (sel < 75) begin
                value = LINE_BITS'(rand_bits64());
                pos = {1'b1, value};
            end else if (sel < 85) begin
                value = line_cursor + LINE_BITS'($urandom_range(3));
                pos = {1'b0, value};
            end
        end
        send_item(cmd, tin, tout, pos);
    endtask

    task automatic test_empty_and_unused();
        send_item(CMD_CLEAR, '0, '0, '0);
        send_item(CMD_RESOLVE, '0, '0, '0);
        send_item(CMD_UNUSED, TIME_MAX, TIME_MAX, '1);
        send_item(CMD_APPEND, TIME_MAX, '0, '0);
    endtask

    task automatic test_clip_extremes();
        send_item(CMD_APPEND, '0, '0, '0);
        send_item(CMD_APPEND, '0, TIME_MAX, '0);
        send_item(CMD_APPEND, TIME_MAX, TIME_MAX, '0);
        send_item(CMD_APPEND, TIME_MAX - TIME_BITS'(7), TIME_MAX, '0);
        send_item(CMD_RESOLVE, '0, '0, '0);
        send_item(CMD_RESOLVE, '0, '0, {5'b0, TIME_MAX});
        send_item(CMD_RESOLVE, '0, '0, {5'b0, TIME_MAX} + POS_BITS'(7));
        send_item(CMD_RESOLVE, '0, '0, {1'b0, {LINE_BITS{1'b1}}});
        send_item(CMD_RESOLVE, '0, '0, {1'b1, {LINE_BITS{1'b0}}});
    endtask

    task automatic test_table_full();
        logic [TIME_BITS-1:0] base;
        base = TIME_BITS'(1000);
        while (clip_total < MAX_CLIPS) begin
            send_item(CMD_APPEND, base, base + TIME_BITS'(5), '0);
            base = base + TIME_BITS'(3);
        end
        send_item(CMD_APPEND, TIME_BITS'(5), TIME_BITS'(1), '0);
    endtask

    task automatic test_drain_pause();
        repeat (20) random_timeline_item();
        wait_results_drained();
        repeat ($urandom_range(1, 20)) @(posedge i_clk);
        repeat (20) random_timeline_item();
    endtask

    task automatic test_random_edits(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count) random_timeline_item();
    endtask

    initial begin
        error_count = 0;
        sender_idle_pct = 0;
        clip_total = 0;
        line_cursor = '0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_command <= CMD_CLEAR;
        i_trim_in <= '0;
        i_trim_out <= '0;
        i_position <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_unused();
        test_clip_extremes();
        test_table_full();
        test_random_edits(300, 0);
        test_drain_pause();
        test_random_edits(300, 78);
        test_random_edits(230, 0);
        test_random_edits(300, 22);

        wait_results_drained();
        repeat (64) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
